@@ hw/rtl/wfm_pkg.sv @@
// shared types, constants and arithmetic helpers of the water/fat magnitude kernel
package wfm_pkg;

    localparam logic [61:0]        CLAMP62   = '1;
    localparam logic signed [63:0] CLAMP62_S = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic [30:0]        ONE_Q30   = 31'h4000_0000;
    localparam logic [28:0]        LOG2E_Q28 = 29'd387270501;
    localparam logic [29:0]        LN2_Q30   = 30'd744261118;
    localparam logic [35:0]        DECAY_LIMIT = 36'd805306368;

    // pipeline stage map
    localparam int ST_CAP       = 0;
    localparam int ST_MUL       = 1;
    localparam int ST_SUM1      = 2;
    localparam int ST_PP        = 3;
    localparam int ST_PPSUM     = 4;
    localparam int ST_ACC1      = 5;
    localparam int ST_ACC2      = 6;
    localparam int ST_ACC3      = 7;
    localparam int ST_TEPP      = 8;
    localparam int ST_TESUM     = 9;
    localparam int ST_NUMABS    = 10;
    localparam int ST_HORNER0   = 5;
    localparam int HORNER_TERMS = 10;
    localparam int ST_EXP       = 35;
    localparam int ST_SQRT0     = 8;
    localparam int SQRT_STEPS   = 32;
    localparam int ST_MAGFIX    = 40;
    localparam int ST_DIVSET    = 41;
    localparam int ST_DIV0      = 42;
    localparam int DIV_BITS     = 62;
    localparam int ST_FIN1      = 104;
    localparam int ST_FIN2      = 105;
    localparam int N_STAGES     = 106;

    typedef struct packed {
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
    } t_pp;

    typedef struct packed {
        // captured beat
        logic signed [31:0] wr, wi, fr, fi, cw, cfr, cfi, meas;
        logic [23:0]        te, r2;
        logic               last;
        // first products
        logic signed [63:0] pwc, pfc, pfi, pic, pfci, pfic, cc1, cc2, ww, wf, ff, wc;
        // sums and numerators
        logic signed [63:0] re, im, n1, cf2, frcf2, wfc, fcf, n2, acc, n3;
        t_pp                pa, pb, pc;
        logic               sa, sb, sc;
        // decay factor
        logic [47:0]        tr;
        logic [29:0]        x;
        logic               big;
        logic [6:0]         ny;
        logic [23:0]        fy;
        logic [29:0]        rr;
        logic [30:0]        tt;
        logic [30:0]        hp;
        logic [63:0]        hpm;
        logic [30:0]        ee;
        // magnitude
        logic [61:0]        u, v;
        logic [4:0]         sh;
        logic [30:0]        us, vs;
        logic [61:0]        sq1, sq2;
        logic [63:0]        sx;
        logic [31:0]        root;
        logic [33:0]        srem;
        logic [61:0]        mag, den;
        // quotients
        logic [2:0][61:0]   dn, dq, drem;
        logic [2:0]         dsg, dovf;
        // final scaling and results
        t_pp [3:0]          fpp;
        logic [31:0]        q_model, q_resid, q_dw, q_df, q_dd;
    } t_item;

    function automatic logic [31:0] f_mag32(logic signed [31:0] a);
        return a[31] ? 32'(-a) : 32'(a);
    endfunction

    function automatic logic [61:0] f_mag64(logic signed [63:0] a);
        return a[63] ? 62'(-a) : 62'(a);
    endfunction

    function automatic logic [61:0] f_sat62(logic [127:0] v);
        return (v > 128'(CLAMP62)) ? CLAMP62 : v[61:0];
    endfunction

    function automatic logic signed [63:0] f_sgn(logic neg, logic [61:0] m);
        logic signed [63:0] x;
        x = $signed({2'b00, m});
        return neg ? -x : x;
    endfunction

    function automatic logic signed [63:0] f_smul32(logic signed [31:0] a,
                                                    logic signed [31:0] b, int frac);
        logic [63:0] p;
        p = 64'(f_mag32(a)) * 64'(f_mag32(b));
        return f_sgn(a[31] ^ b[31], f_sat62(128'(p) >> frac));
    endfunction

    function automatic logic signed [63:0] f_sadd(logic signed [63:0] a,
                                                  logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (s > CLAMP62_S) return CLAMP62_S;
        if (s < -CLAMP62_S) return -CLAMP62_S;
        return s;
    endfunction

    function automatic t_pp f_pp(logic [63:0] a, logic [63:0] b);
        t_pp p;
        p.p00 = 64'(a[31:0]) * 64'(b[31:0]);
        p.p01 = 64'(a[31:0]) * 64'(b[63:32]);
        p.p10 = 64'(a[63:32]) * 64'(b[31:0]);
        p.p11 = 64'(a[63:32]) * 64'(b[63:32]);
        return p;
    endfunction

    function automatic logic [127:0] f_ppsum(t_pp p);
        return {64'b0, p.p00} + {32'b0, p.p01, 32'b0} + {32'b0, p.p10, 32'b0}
             + {p.p11, 64'b0};
    endfunction

    function automatic logic [31:0] f_out32(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [4:0] f_bitlen31(logic [30:0] w);
        logic [4:0] b;
        b = '0;
        for (int i = 0; i < 31; i++) begin
            if (w[i]) b = 5'(i + 1);
        end
        return b;
    endfunction

endpackage

@@ hw/rtl/wfm_if.sv @@
// valid/ready channels for echo beats in and result beats out
interface wfm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] water_re;
    logic signed [31:0] water_im;
    logic signed [31:0] fat_re;
    logic signed [31:0] fat_im;
    logic [23:0]        decay_rate;
    logic [23:0]        echo_time;
    logic signed [31:0] water_coef;
    logic signed [31:0] fat_coef_re;
    logic signed [31:0] fat_coef_im;
    logic signed [31:0] measured_mag;
    logic               last_echo;

    modport source (output valid, water_re, water_im, fat_re, fat_im, decay_rate, echo_time,
                    water_coef, fat_coef_re, fat_coef_im, measured_mag, last_echo,
                    input ready);
    modport sink (input valid, water_re, water_im, fat_re, fat_im, decay_rate, echo_time,
                  water_coef, fat_coef_re, fat_coef_im, measured_mag, last_echo,
                  output ready);
endinterface

interface wfm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] model_mag;
    logic signed [31:0] residual;
    logic signed [31:0] d_water_re;
    logic signed [31:0] d_fat_re;
    logic signed [31:0] d_decay;
    logic               last_of_run;

    modport source (output valid, model_mag, residual, d_water_re, d_fat_re, d_decay,
                    last_of_run, input ready);
    modport sink (input valid, model_mag, residual, d_water_re, d_fat_re, d_decay,
                  last_of_run, output ready);
endinterface

@@ hw/rtl/wfm_stage.sv @@
// one register stage of the kernel pipeline, its step chosen by stage index
module wfm_stage #(
    parameter int STAGE     = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  wfm_pkg::t_item i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output wfm_pkg::t_item o_data
);
    import wfm_pkg::*;

    // horner step of the exp series
    localparam int  HOFF = STAGE - ST_HORNER0;
    localparam bit  IS_H = (STAGE >= ST_HORNER0) && (STAGE < ST_HORNER0 + 3 * HORNER_TERMS);
    localparam int  HJ   = IS_H ? HOFF / 3 : 0;
    localparam int  HPH  = IS_H ? HOFF % 3 : 0;
    localparam int  HKD  = HORNER_TERMS - HJ;
    localparam logic [32:0] HM   = 33'((64'd1 << 32) / HKD);
    localparam logic [31:0] HKDV = 32'(HKD);

    // square root digit
    localparam bit  IS_SQ = (STAGE >= ST_SQRT0) && (STAGE < ST_SQRT0 + SQRT_STEPS);
    localparam int  SQI   = IS_SQ ? (SQRT_STEPS - 1) - (STAGE - ST_SQRT0) : 0;
    localparam logic [5:0] SQB_LO = 6'(2 * SQI);
    localparam logic [5:0] SQB_HI = 6'(2 * SQI + 1);

    // quotient bit
    localparam bit  IS_DV = (STAGE >= ST_DIV0) && (STAGE < ST_DIV0 + DIV_BITS);
    localparam int  DVI   = IS_DV ? (DIV_BITS - 1) - (STAGE - ST_DIV0) : 0;
    localparam int  DNB   = DVI - FRAC_BITS;
    localparam logic [5:0] DVI_IDX = 6'(DVI);
    localparam logic [5:0] DNB_IDX = 6'((DNB >= 0) ? DNB : 0);

    logic  r_valid;
    t_item r_data;
    t_item n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        logic [61:0]  m;
        logic [61:0]  m0;
        logic [61:0]  w;
        logic [58:0]  yp;
        logic [53:0]  rp;
        logic [60:0]  hprod;
        logic [31:0]  q0;
        logic [31:0]  hrem;
        logic [31:0]  hq;
        logic [35:0]  rem2;
        logic [35:0]  trial;
        logic [62:0]  rsh;
        logic [62:0]  drem2;
        logic         nbit;
        m     = '0;
        m0    = '0;
        w     = '0;
        yp    = '0;
        rp    = '0;
        hprod = '0;
        q0    = '0;
        hrem  = '0;
        hq    = '0;
        rem2  = '0;
        trial = '0;
        rsh   = '0;
        drem2 = '0;
        nbit  = 1'b0;
        n_data = i_data;

        if (STAGE == ST_MUL) begin
            n_data.pwc  = f_smul32(i_data.wr, i_data.cw, FRAC_BITS);
            n_data.pfc  = f_smul32(i_data.fr, i_data.cfr, FRAC_BITS);
            n_data.pfi  = f_smul32(i_data.fi, i_data.cfi, FRAC_BITS);
            n_data.pic  = f_smul32(i_data.wi, i_data.cw, FRAC_BITS);
            n_data.pfci = f_smul32(i_data.fr, i_data.cfi, FRAC_BITS);
            n_data.pfic = f_smul32(i_data.fi, i_data.cfr, FRAC_BITS);
            n_data.cc1  = f_smul32(i_data.cfr, i_data.cfr, FRAC_BITS);
            n_data.cc2  = f_smul32(i_data.cfi, i_data.cfi, FRAC_BITS);
            n_data.ww   = f_smul32(i_data.wr, i_data.wr, FRAC_BITS);
            n_data.wf   = f_smul32(i_data.wr, i_data.fr, FRAC_BITS);
            n_data.ff   = f_smul32(i_data.fr, i_data.fr, FRAC_BITS);
            n_data.wc   = f_smul32(i_data.wr, i_data.cfr, FRAC_BITS);
            n_data.tr   = 48'(i_data.te) * 48'(i_data.r2);
        end

        if (STAGE == ST_SUM1) begin
            n_data.re  = f_sadd(f_sadd(i_data.pwc, i_data.pfc), -i_data.pfi);
            n_data.im  = f_sadd(f_sadd(i_data.pic, i_data.pfci), i_data.pfic);
            n_data.n1  = f_sadd(i_data.pwc, i_data.pfc);
            n_data.cf2 = f_sadd(i_data.cc1, i_data.cc2);
            n_data.big = i_data.tr[47:12] >= DECAY_LIMIT;
            n_data.x   = i_data.tr[41:12];
        end

        if (STAGE == ST_PP) begin
            n_data.u  = f_mag64(i_data.re);
            n_data.v  = f_mag64(i_data.im);
            n_data.pa = f_pp(64'(f_mag32(i_data.fr)), 64'(f_mag64(i_data.cf2)));
            n_data.sa = i_data.fr[31] ^ i_data.cf2[63];
            n_data.pb = f_pp(64'(f_mag64(i_data.wf)), 64'(f_mag32(i_data.cfr)));
            n_data.sb = i_data.wf[63] ^ i_data.cfr[31];
            n_data.pc = f_pp(64'(f_mag64(i_data.ff)), 64'(f_mag64(i_data.cf2)));
            n_data.sc = i_data.ff[63] ^ i_data.cf2[63];
            yp        = 59'(i_data.x) * 59'(LOG2E_Q28);
            n_data.ny = yp[58:52];
            n_data.fy = yp[51:28];
        end

        if (STAGE == ST_PPSUM) begin
            n_data.frcf2 = f_sgn(i_data.sa, f_sat62(f_ppsum(i_data.pa) >> FRAC_BITS));
            n_data.wfc   = f_sgn(i_data.sb, f_sat62(f_ppsum(i_data.pb) >> FRAC_BITS));
            n_data.fcf   = f_sgn(i_data.sc, f_sat62(f_ppsum(i_data.pc) >> FRAC_BITS));
            w            = i_data.u | i_data.v;
            n_data.sh    = f_bitlen31(w[61:31]);
            rp           = 54'(i_data.fy) * 54'(LN2_Q30);
            n_data.rr    = rp[53:24];
            n_data.tt    = ONE_Q30;
        end

        if (STAGE == ST_ACC1) begin
            n_data.n2  = f_sadd(i_data.frcf2, i_data.wc);
            n_data.acc = f_sadd(i_data.ww, i_data.wfc);
            n_data.us  = 31'(i_data.u >> i_data.sh);
            n_data.vs  = 31'(i_data.v >> i_data.sh);
        end

        if (STAGE == ST_ACC2) begin
            n_data.acc = f_sadd(i_data.acc, i_data.fcf);
            n_data.sq1 = 62'(i_data.us) * 62'(i_data.us);
            n_data.sq2 = 62'(i_data.vs) * 62'(i_data.vs);
        end

        if (STAGE == ST_ACC3) begin
            n_data.acc  = f_sadd(i_data.acc, i_data.wfc);
            n_data.sx   = 64'(i_data.sq1) + 64'(i_data.sq2);
            n_data.srem = '0;
            n_data.root = '0;
        end

        if (STAGE == ST_TEPP) begin
            n_data.pa = f_pp(64'(f_mag64(i_data.acc)), 64'(i_data.te));
            n_data.sa = i_data.acc[63];
        end

        if (STAGE == ST_TESUM) begin
            m         = f_sat62(f_ppsum(i_data.pa) >> 24);
            n_data.n3 = f_sgn(!i_data.sa, m);
        end

        if (STAGE == ST_NUMABS) begin
            n_data.dn[0]  = f_mag64(i_data.n1);
            n_data.dn[1]  = f_mag64(i_data.n2);
            n_data.dn[2]  = f_mag64(i_data.n3);
            n_data.dsg[0] = i_data.n1[63];
            n_data.dsg[1] = i_data.n2[63];
            n_data.dsg[2] = i_data.n3[63];
        end

        if (IS_H) begin
            if (HPH == 0) begin
                hprod     = 61'(i_data.rr) * 61'(i_data.tt);
                n_data.hp = hprod[60:30];
            end else if (HPH == 1) begin
                n_data.hpm = 64'(i_data.hp) * 64'(HM);
            end else begin
                // reciprocal estimate is low by at most one
                q0        = i_data.hpm[63:32];
                hrem      = 32'(i_data.hp) - q0 * HKDV;
                hq        = q0 + ((hrem >= HKDV) ? 32'd1 : 32'd0);
                n_data.tt = ONE_Q30 - 31'(hq);
            end
        end

        if (STAGE == ST_EXP) begin
            n_data.ee = (i_data.big || (i_data.ny >= 7'd31)) ? '0 : (i_data.tt >> i_data.ny);
        end

        if (IS_SQ) begin
            rem2  = {i_data.srem, i_data.sx[SQB_HI], i_data.sx[SQB_LO]};
            trial = 36'({i_data.root, 2'b01});
            if (rem2 >= trial) begin
                n_data.srem = 34'(rem2 - trial);
                n_data.root = {i_data.root[30:0], 1'b1};
            end else begin
                n_data.srem = rem2[33:0];
                n_data.root = {i_data.root[30:0], 1'b0};
            end
        end

        if (STAGE == ST_MAGFIX) begin
            rsh        = 63'(i_data.root) << i_data.sh;
            m          = (rsh > 63'(CLAMP62)) ? CLAMP62 : rsh[61:0];
            n_data.mag = m;
            n_data.den = (m == '0) ? 62'd1 : m;
        end

        if (STAGE == ST_DIVSET) begin
            for (int c = 0; c < 3; c++) begin
                m               = 62'(i_data.dn[c] >> (DIV_BITS - FRAC_BITS));
                n_data.drem[c]  = m;
                n_data.dovf[c]  = m >= i_data.den;
                n_data.dq[c]    = '0;
            end
        end

        if (IS_DV) begin
            for (int c = 0; c < 3; c++) begin
                nbit  = (DNB >= 0) ? i_data.dn[c][DNB_IDX] : 1'b0;
                drem2 = {i_data.drem[c], nbit};
                if (drem2 >= {1'b0, i_data.den}) begin
                    n_data.drem[c]        = 62'(drem2 - {1'b0, i_data.den});
                    n_data.dq[c][DVI_IDX] = 1'b1;
                end else begin
                    n_data.drem[c] = drem2[61:0];
                end
            end
        end

        if (STAGE == ST_FIN1) begin
            n_data.fpp[0] = f_pp(64'(i_data.ee), 64'(i_data.mag));
            for (int c = 0; c < 3; c++) begin
                n_data.fpp[c + 1] = f_pp(64'(i_data.ee),
                                         64'(i_data.dovf[c] ? CLAMP62 : i_data.dq[c]));
            end
        end

        if (STAGE == ST_FIN2) begin
            m0              = f_sat62(f_ppsum(i_data.fpp[0]) >> 30);
            n_data.q_model  = f_out32(f_sgn(1'b0, m0));
            n_data.q_resid  = f_out32(f_sgn(1'b0, m0) - 64'(i_data.meas));
            m               = f_sat62(f_ppsum(i_data.fpp[1]) >> 30);
            n_data.q_dw     = f_out32(f_sgn(i_data.dsg[0], m));
            m               = f_sat62(f_ppsum(i_data.fpp[2]) >> 30);
            n_data.q_df     = f_out32(f_sgn(i_data.dsg[1], m));
            m               = f_sat62(f_ppsum(i_data.fpp[3]) >> 30);
            n_data.q_dd     = f_out32(f_sgn(i_data.dsg[2], m));
        end
    end

endmodule

@@ hw/rtl/water_fat_magnitude_residual_jacobian_core.sv @@
// Water/fat magnitude kernel: per echo beat it forms S = W*cw + F*cf and the decay
// factor E = exp(-te*r2), and returns E*|S|, the residual against the measured
// magnitude and three Jacobian terms, all signed Q16.16 saturated to 32 bits. The
// kernel is a fully pipelined chain of 106 register stages, so one echo beat enters
// every cycle when the output side does not stall. The depth is set by the 62
// one-bit quotient steps that divide the three Jacobian numerators by |S| after the
// 32-step square root; the exp series runs in parallel with the numerator sums and
// the square root. Each stage holds its beat until the next stage frees, so a stall
// only squeezes out bubbles and nothing is dropped or repeated. No clearing pass or
// stored state exists: every echo is independent.
module water_fat_magnitude_residual_jacobian_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wfm_in_if.sink    i_in,
    wfm_out_if.source o_out
);
    import wfm_pkg::*;

    // stage chain: w_*[k] feeds stage k, w_*[N_STAGES] is the output register
    t_item w_data  [N_STAGES + 1];
    logic  w_valid [N_STAGES + 1];
    logic  w_ready [N_STAGES + 1];

    // capture the input beat into the working record
    always_comb begin
        w_data[0]      = '0;
        w_data[0].wr   = i_in.water_re;
        w_data[0].wi   = i_in.water_im;
        w_data[0].fr   = i_in.fat_re;
        w_data[0].fi   = i_in.fat_im;
        w_data[0].r2   = i_in.decay_rate;
        w_data[0].te   = i_in.echo_time;
        w_data[0].cw   = i_in.water_coef;
        w_data[0].cfr  = i_in.fat_coef_re;
        w_data[0].cfi  = i_in.fat_coef_im;
        w_data[0].meas = i_in.measured_mag;
        w_data[0].last = i_in.last_echo;
    end

    assign w_valid[0]  = i_in.valid;
    assign i_in.ready  = w_ready[0];

    // products, sums, square root, exp series, quotient steps, final scaling
    for (genvar k = 0; k < N_STAGES; k++) begin : g_stage
        wfm_stage #(
            .STAGE     (k),
            .FRAC_BITS (FRAC_BITS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k + 1]),
            .i_ready (w_ready[k + 1]),
            .o_data  (w_data[k + 1])
        );
    end

    // last stage register drives the result beat
    assign o_out.valid       = w_valid[N_STAGES];
    assign w_ready[N_STAGES] = o_out.ready;
    assign o_out.model_mag   = $signed(w_data[N_STAGES].q_model);
    assign o_out.residual    = $signed(w_data[N_STAGES].q_resid);
    assign o_out.d_water_re  = $signed(w_data[N_STAGES].q_dw);
    assign o_out.d_fat_re    = $signed(w_data[N_STAGES].q_df);
    assign o_out.d_decay     = $signed(w_data[N_STAGES].q_dd);
    assign o_out.last_of_run = w_data[N_STAGES].last;

endmodule
